@@ rtl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared sizes, status codes, micro-operations and flag bundle for the
// max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int POS_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int OCC_W    = 7;
	localparam int STATUS_W = 2;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [KEY_W-1:0]  key_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// datapath micro-operations, one per control word
	typedef enum logic [3:0] {
		U_NOP,
		U_LOAD_IN,
		U_INS_INIT,
		U_RD_PARENT,
		U_SWIM_STEP,
		U_RD_ROOT,
		U_RD_LAST_SAVE_MAX,
		U_SINK_INIT,
		U_RD_LEFT,
		U_RD_RIGHT_SAVE_LEFT,
		U_SINK_PICK,
		U_SINK_STEP,
		U_PLACE,
		U_SET_FULL,
		U_SET_EMPTY,
		U_FINISH
	} uop_t;

	// condition inputs from datapath to sequencer
	typedef struct packed {
		logic kind_rem;
		logic full;
		logic empty;
		logic pos_root;
		logic leaf;
		logic key_gt_rd;
		logic cv_gt_key;
	} dp_flags_t;

endpackage

@@ rtl/mhpq_seq.sv @@
// ----------------------------------------------------------------------------
// mhpq_seq
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// ----------------------------------------------------------------------------
module mhpq_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                out_busy,
	input  mhpq_pkg::dp_flags_t flags,
	output mhpq_pkg::uop_t      op,
	output logic                idle
);
	import mhpq_pkg::*;

	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_NOT_START,
		C_KIND_REM,
		C_FULL,
		C_EMPTY,
		C_POS_ROOT,
		C_LEAF,
		C_KEY_GT_RD,
		C_CV_GT_KEY,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} cword_t;

	localparam step_t S_IDLE      = 5'd0;
	localparam step_t S_DISPATCH  = 5'd1;
	localparam step_t S_INS_CHK   = 5'd2;
	localparam step_t S_INS_INIT  = 5'd3;
	localparam step_t S_SWIM_RD   = 5'd4;
	localparam step_t S_SWIM_STEP = 5'd5;
	localparam step_t S_SWIM_END  = 5'd6;
	localparam step_t S_REM       = 5'd7;
	localparam step_t S_RD_ROOT   = 5'd8;
	localparam step_t S_RD_LAST   = 5'd9;
	localparam step_t S_SINK_INIT = 5'd10;
	localparam step_t S_SINK_RD   = 5'd11;
	localparam step_t S_RD_RIGHT  = 5'd12;
	localparam step_t S_SINK_PICK = 5'd13;
	localparam step_t S_SINK_STEP = 5'd14;
	localparam step_t S_PLACE     = 5'd15;
	localparam step_t S_SET_FULL  = 5'd16;
	localparam step_t S_SET_EMPTY = 5'd17;
	localparam step_t S_FINISH    = 5'd18;
	localparam step_t S_RETURN    = 5'd19;

	function automatic cword_t rom(input step_t s);
		cword_t w;
		unique case (s)
			S_IDLE:      w = '{U_LOAD_IN,            C_NOT_START, S_IDLE};
			S_DISPATCH:  w = '{U_NOP,                C_KIND_REM,  S_REM};
			S_INS_CHK:   w = '{U_NOP,                C_FULL,      S_SET_FULL};
			S_INS_INIT:  w = '{U_INS_INIT,           C_NONE,      S_IDLE};
			S_SWIM_RD:   w = '{U_RD_PARENT,          C_POS_ROOT,  S_PLACE};
			S_SWIM_STEP: w = '{U_SWIM_STEP,          C_KEY_GT_RD, S_SWIM_RD};
			S_SWIM_END:  w = '{U_NOP,                C_ALWAYS,    S_PLACE};
			S_REM:       w = '{U_NOP,                C_EMPTY,     S_SET_EMPTY};
			S_RD_ROOT:   w = '{U_RD_ROOT,            C_NONE,      S_IDLE};
			S_RD_LAST:   w = '{U_RD_LAST_SAVE_MAX,   C_NONE,      S_IDLE};
			S_SINK_INIT: w = '{U_SINK_INIT,          C_NONE,      S_IDLE};
			S_SINK_RD:   w = '{U_RD_LEFT,            C_LEAF,      S_PLACE};
			S_RD_RIGHT:  w = '{U_RD_RIGHT_SAVE_LEFT, C_NONE,      S_IDLE};
			S_SINK_PICK: w = '{U_SINK_PICK,          C_NONE,      S_IDLE};
			S_SINK_STEP: w = '{U_SINK_STEP,          C_CV_GT_KEY, S_SINK_RD};
			S_PLACE:     w = '{U_PLACE,              C_ALWAYS,    S_FINISH};
			S_SET_FULL:  w = '{U_SET_FULL,           C_ALWAYS,    S_FINISH};
			S_SET_EMPTY: w = '{U_SET_EMPTY,          C_NONE,      S_IDLE};
			S_FINISH:    w = '{U_FINISH,             C_OUT_BUSY,  S_FINISH};
			S_RETURN:    w = '{U_NOP,                C_ALWAYS,    S_IDLE};
			default:     w = '{U_NOP,                C_ALWAYS,    S_IDLE};
		endcase
		return w;
	endfunction

	step_t  upc_q;
	cword_t cw;
	logic   take;

	assign cw   = rom(upc_q);
	assign op   = cw.op;
	assign idle = (upc_q == S_IDLE);

	always_comb begin
		unique case (cw.cond)
			C_NONE:      take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NOT_START: take = !start;
			C_KIND_REM:  take = flags.kind_rem;
			C_FULL:      take = flags.full;
			C_EMPTY:     take = flags.empty;
			C_POS_ROOT:  take = flags.pos_root;
			C_LEAF:      take = flags.leaf;
			C_KEY_GT_RD: take = flags.key_gt_rd;
			C_CV_GT_KEY: take = flags.cv_gt_key;
			C_OUT_BUSY:  take = out_busy;
			default:     take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= take ? cw.target : upc_q + step_t'(1);
		end
	end

endmodule

@@ rtl/mhpq_dp.sv @@
// ----------------------------------------------------------------------------
// mhpq_dp
// Heap datapath: one-write, one-read heap memory with registered read, moving key,
// position and child registers, entry count and result registers.
// ----------------------------------------------------------------------------
module mhpq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mhpq_pkg::uop_t      op,
	input  logic                in_kind,
	input  mhpq_pkg::key_t      in_value,
	output mhpq_pkg::dp_flags_t flags,
	output mhpq_pkg::status_t   res_status,
	output mhpq_pkg::key_t      res_max,
	output mhpq_pkg::pos_t      res_count
);
	import mhpq_pkg::*;

	key_t mem [CAPACITY];

	key_t    rd_q;
	key_t    key_q;
	key_t    lv_q;
	key_t    cv_q;
	key_t    max_q;
	pos_t    pos_q;
	pos_t    c_q;
	pos_t    cnt_q;
	logic    kind_q;
	status_t status_q;

	logic [POS_W:0] lchild;
	logic           has_right;
	logic           right_wins;
	logic           key_gt_rd;
	logic           cv_gt_key;
	pos_t           parent;
	addr_t          rd_addr;
	logic           we;
	key_t           wd;

	// slot p lives at memory index p-1
	assign lchild     = {pos_q, 1'b0};
	assign has_right  = lchild < {1'b0, cnt_q};
	assign parent     = pos_q >> 1;
	assign key_gt_rd  = $signed(key_q) > $signed(rd_q);
	assign cv_gt_key  = $signed(cv_q) > $signed(key_q);
	assign right_wins = has_right && ($signed(rd_q) > $signed(lv_q));

	assign flags.kind_rem  = kind_q;
	assign flags.full      = (cnt_q == POS_W'(CAPACITY));
	assign flags.empty     = (cnt_q == '0);
	assign flags.pos_root  = (pos_q == pos_t'(1));
	assign flags.leaf      = lchild > {1'b0, cnt_q};
	assign flags.key_gt_rd = key_gt_rd;
	assign flags.cv_gt_key = cv_gt_key;

	assign res_status = status_q;
	assign res_max    = max_q;
	assign res_count  = cnt_q;

	always_comb begin
		rd_addr = addr_t'(pos_q - pos_t'(1));
		we      = 1'b0;
		wd      = key_q;
		unique case (op)
			U_RD_PARENT:          rd_addr = addr_t'(parent - pos_t'(1));
			U_RD_ROOT:            rd_addr = '0;
			U_RD_LAST_SAVE_MAX:   rd_addr = addr_t'(cnt_q - pos_t'(1));
			U_RD_LEFT:            rd_addr = addr_t'(lchild - 1'b1);
			U_RD_RIGHT_SAVE_LEFT: rd_addr = addr_t'(lchild);
			U_SWIM_STEP: begin
				we = key_gt_rd;
				wd = rd_q;
			end
			U_SINK_STEP: begin
				we = cv_gt_key;
				wd = cv_q;
			end
			U_PLACE:              we = 1'b1;
			default:              we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr_t'(pos_q - pos_t'(1))] <= wd;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case (op)
				U_INS_INIT:  cnt_q <= cnt_q + pos_t'(1);
				U_SINK_INIT: cnt_q <= cnt_q - pos_t'(1);
				default:     cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			U_LOAD_IN: begin
				kind_q   <= in_kind;
				key_q    <= in_value;
				max_q    <= '0;
				status_q <= ST_OK;
			end
			U_INS_INIT:  pos_q <= cnt_q + pos_t'(1);
			U_SWIM_STEP: begin
				if (key_gt_rd) begin
					pos_q <= parent;
				end
			end
			U_RD_LAST_SAVE_MAX:   max_q <= rd_q;
			U_SINK_INIT: begin
				key_q <= rd_q;
				pos_q <= pos_t'(1);
			end
			U_RD_RIGHT_SAVE_LEFT: lv_q <= rd_q;
			U_SINK_PICK: begin
				if (right_wins) begin
					cv_q <= rd_q;
					c_q  <= pos_t'(lchild + 1'b1);
				end else begin
					cv_q <= lv_q;
					c_q  <= pos_t'(lchild);
				end
			end
			U_SINK_STEP: begin
				if (cv_gt_key) begin
					pos_q <= c_q;
				end
			end
			U_SET_FULL:  status_q <= ST_FULL;
			U_SET_EMPTY: status_q <= ST_EMPTY;
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/max_heap_priority_queue.sv @@
// A request is accepted only in the idle step, so each insert (swim up) or remove
// (sink down) runs to its end before the next is taken; a full insert or empty
// remove skips the heap walk. The result is valid before the next accept; the
// last step waits while an earlier result stalls.
// Reset clears entry count, sequencer and output valid, not the heap memory.
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue: insert a signed key or remove the maximum,
// one result per request with status, removed key and occupancy.
// ----------------------------------------------------------------------------
module max_heap_priority_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           kind,
	input  logic signed [mhpq_pkg::KEY_W-1:0]    value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mhpq_pkg::STATUS_W-1:0]  status,
	output logic signed [mhpq_pkg::KEY_W-1:0]    max_value,
	output logic [mhpq_pkg::OCC_W-1:0]     occupancy
);
	import mhpq_pkg::*;

	uop_t      op;
	dp_flags_t flags;
	status_t   res_status;
	key_t      res_max;
	pos_t      res_count;
	logic      idle;
	logic      out_busy;
	logic      out_valid_q;
	status_t   status_q;
	key_t      max_q;
	logic [OCC_W-1:0] occ_q;

	assign out_busy  = out_valid_q && out_stall;
	assign in_stall  = !idle;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign max_value = max_q;
	assign occupancy = occ_q;

	mhpq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid),
		.out_busy (out_busy),
		.flags    (flags),
		.op       (op),
		.idle     (idle)
	);

	mhpq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.in_kind    (kind),
		.in_value   (value),
		.flags      (flags),
		.res_status (res_status),
		.res_max    (res_max),
		.res_count  (res_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == U_FINISH && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == U_FINISH && !out_busy) begin
			status_q <= res_status;
			max_q    <= res_max;
			occ_q    <= OCC_W'(res_count);
		end
	end

endmodule
